>>> hdl/tcw_pkg.sv
// Shared types, sizes and codes of the text console writer.
package tcw_pkg;

  localparam int ROWS    = 25;
  localparam int COLS    = 80;
  localparam int CELLS   = ROWS * COLS;
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int CNT_W   = $clog2(CELLS + 1);
  localparam int ROW_W   = $clog2(ROWS);
  localparam int COL_W   = $clog2(COLS + 1);
  localparam int CELL_W  = 16;

  localparam int QDEPTH  = 2;
  localparam int Q_PTR_W = $clog2(QDEPTH);
  localparam int Q_CNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] SPACE_CODE   = 8'd32;
  localparam int         BG_SHIFT     = 4;

  localparam logic [3:0] RESET_FG   = 4'hF;
  localparam logic [3:0] RESET_BG   = 4'h0;
  localparam logic [7:0] RESET_ATTR = {RESET_BG, RESET_FG};

  // Configuration register indexes.
  localparam logic REG_FG = 1'b0;
  localparam logic REG_BG = 1'b1;

  typedef enum logic [1:0] {
    OP_PUT    = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_READ   = 2'd2,
    OP_UNUSED = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    K_PUT,
    K_NEWLINE,
    K_CLEAR,
    K_READ,
    K_NOP
  } kind_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } in_item_t;

  typedef struct packed {
    logic [4:0] cursor_row_out;
    logic [6:0] cursor_col_out;
    logic [7:0] read_char;
    logic [7:0] read_attr;
  } out_item_t;

  typedef struct packed {
    kind_t             kind;
    logic [7:0]        char_code;
    logic [ADDR_W-1:0] addr;
  } cmd_t;

endpackage

>>> hdl/tcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/tcw_front.sv
// Front end: accepts items, decodes them into commands and queues them.
module tcw_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  tcw_pkg::in_item_t in_data,
  output logic             q_valid,
  input  logic             q_ready,
  output tcw_pkg::cmd_t    q_cmd
);

  tcw_pkg::cmd_t                  entry_r [tcw_pkg::QDEPTH];
  logic [tcw_pkg::Q_PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [tcw_pkg::Q_PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [tcw_pkg::Q_CNT_W-1:0]    fill_r, fill_nxt;
  tcw_pkg::cmd_t                  dec_cmd;
  logic                           push, pop;

  // An out-of-range read becomes a no-op so the back end never sees a bad address.
  always_comb begin
    dec_cmd.char_code = in_data.char_code;
    dec_cmd.addr      = tcw_pkg::ADDR_W'(in_data.cell_index);
    case (in_data.operation)
      tcw_pkg::OP_PUT: begin
        dec_cmd.kind = (in_data.char_code == tcw_pkg::NEWLINE_CODE) ?
                       tcw_pkg::K_NEWLINE : tcw_pkg::K_PUT;
      end
      tcw_pkg::OP_CLEAR: begin
        dec_cmd.kind = tcw_pkg::K_CLEAR;
      end
      tcw_pkg::OP_READ: begin
        dec_cmd.kind = (int'(in_data.cell_index) < tcw_pkg::CELLS) ?
                       tcw_pkg::K_READ : tcw_pkg::K_NOP;
      end
      default: begin
        dec_cmd.kind = tcw_pkg::K_NOP;
      end
    endcase
  end

  assign in_ready = (fill_r != tcw_pkg::Q_CNT_W'(tcw_pkg::QDEPTH));
  assign q_valid  = (fill_r != '0);
  assign q_cmd    = entry_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == tcw_pkg::Q_PTR_W'(tcw_pkg::QDEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == tcw_pkg::Q_PTR_W'(tcw_pkg::QDEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= dec_cmd;
    end
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

endmodule

>>> hdl/tcw_back.sv
// Back end: sequencer that owns the frame store and the cursor and builds results.
module tcw_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [7:0]          attr,
  input  logic                q_valid,
  output logic                q_ready,
  input  tcw_pkg::cmd_t       q_cmd,
  output logic                out_valid,
  input  logic                out_ready,
  output tcw_pkg::out_item_t  out_data
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_CLEAR,
    S_SCROLL,
    S_BLANK,
    S_PUT,
    S_DONE
  } state_t;

  state_t                         state_r, state_nxt;
  logic [tcw_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [tcw_pkg::ROW_W-1:0]      row_r, row_nxt;
  logic [tcw_pkg::COL_W-1:0]      col_r, col_nxt;
  tcw_pkg::cmd_t                  cmd_r, cmd_nxt;
  logic                           out_valid_r, out_valid_nxt;
  tcw_pkg::out_item_t             out_r, out_nxt;

  logic                           ram_we, ram_re;
  logic [tcw_pkg::ADDR_W-1:0]     ram_waddr, ram_raddr;
  logic [tcw_pkg::CELL_W-1:0]     ram_wdata, ram_rdata;

  logic [tcw_pkg::ADDR_W-1:0]     cur_addr;
  logic [tcw_pkg::CNT_W-1:0]      copy_dst;
  logic                           last_row, col_full, out_free;

  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (tcw_pkg::CELLS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cur_addr = tcw_pkg::ADDR_W'(row_r) * tcw_pkg::ADDR_W'(tcw_pkg::COLS)
                  + tcw_pkg::ADDR_W'(col_r);
  assign copy_dst = cnt_r - tcw_pkg::CNT_W'(tcw_pkg::COLS + 1);
  assign last_row = (row_r == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1));
  assign col_full = (col_r >= tcw_pkg::COL_W'(tcw_pkg::COLS));
  assign out_free = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    cmd_nxt       = cmd_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    q_ready       = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = '0;

    case (state_r)
      S_INIT, S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r[tcw_pkg::ADDR_W-1:0];
        ram_wdata = {(state_r == S_INIT) ? tcw_pkg::RESET_ATTR : attr,
                     tcw_pkg::SPACE_CODE};
        if (cnt_r == tcw_pkg::CNT_W'(tcw_pkg::CELLS - 1)) begin
          state_nxt = (state_r == S_INIT) ? S_IDLE : S_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      S_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          cmd_nxt = q_cmd;
          case (q_cmd.kind)
            tcw_pkg::K_PUT, tcw_pkg::K_NEWLINE: begin
              if (q_cmd.kind == tcw_pkg::K_PUT && !col_full) begin
                // Common case: store the character straight away.
                ram_we    = 1'b1;
                ram_waddr = cur_addr;
                ram_wdata = {attr, q_cmd.char_code};
                col_nxt   = col_r + 1'b1;
                state_nxt = S_DONE;
              end else begin
                col_nxt = '0;
                if (!last_row) begin
                  row_nxt   = row_r + 1'b1;
                  state_nxt = (q_cmd.kind == tcw_pkg::K_PUT) ? S_PUT : S_DONE;
                end else begin
                  cnt_nxt   = tcw_pkg::CNT_W'(tcw_pkg::COLS);
                  state_nxt = S_SCROLL;
                end
              end
            end
            tcw_pkg::K_CLEAR: begin
              cnt_nxt   = '0;
              state_nxt = S_CLEAR;
            end
            tcw_pkg::K_READ: begin
              ram_re    = 1'b1;
              ram_raddr = q_cmd.addr;
              state_nxt = S_DONE;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      // Each cycle reads the cell one row down and writes the cell read the
      // cycle before into the row above it.
      S_SCROLL: begin
        if (cnt_r < tcw_pkg::CNT_W'(tcw_pkg::CELLS)) begin
          ram_re    = 1'b1;
          ram_raddr = cnt_r[tcw_pkg::ADDR_W-1:0];
        end
        if (cnt_r > tcw_pkg::CNT_W'(tcw_pkg::COLS)) begin
          ram_we    = 1'b1;
          ram_waddr = copy_dst[tcw_pkg::ADDR_W-1:0];
          ram_wdata = ram_rdata;
        end
        if (cnt_r == tcw_pkg::CNT_W'(tcw_pkg::CELLS)) begin
          cnt_nxt   = tcw_pkg::CNT_W'((tcw_pkg::ROWS - 1) * tcw_pkg::COLS);
          state_nxt = S_BLANK;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      S_BLANK: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r[tcw_pkg::ADDR_W-1:0];
        ram_wdata = {attr, tcw_pkg::SPACE_CODE};
        if (cnt_r == tcw_pkg::CNT_W'(tcw_pkg::CELLS - 1)) begin
          state_nxt = (cmd_r.kind == tcw_pkg::K_PUT) ? S_PUT : S_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = cur_addr;
        ram_wdata = {attr, cmd_r.char_code};
        col_nxt   = col_r + 1'b1;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_nxt.cursor_row_out = 5'(row_r);
          out_nxt.cursor_col_out = 7'(col_r);
          if (cmd_r.kind == tcw_pkg::K_READ) begin
            out_nxt.read_char = ram_rdata[7:0];
            out_nxt.read_attr = ram_rdata[15:8];
          end else begin
            out_nxt.read_char = '0;
            out_nxt.read_attr = '0;
          end
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    out_r <= out_nxt;
    if (!rst_n) begin
      state_r     <= S_INIT;
      cnt_r       <= '0;
      row_r       <= '0;
      col_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> hdl/text_console_writer.sv
// Put without a pending wrap, newline, read and unused items: dequeue and result steps of the
// sequencer, result registered; the result step waits while the output is held, and no new
// item is taken before it. A put with a wrap pending adds a store step on the new row; on the
// last row a newline or wrapping put adds a copy pass and a blank pass; a clear adds a pass
// over all cells. After reset all ROWS*COLS cells (2000) are cleared; up to two items are
// queued meanwhile and run afterwards, and configuration writes are taken throughout.
module text_console_writer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tcw_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tcw_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [3:0]         cfg_wdata
);

  logic [3:0]     fg_r, fg_nxt;
  logic [3:0]     bg_r, bg_nxt;
  logic [7:0]     attr;
  logic           q_valid, q_ready;
  tcw_pkg::cmd_t  q_cmd;

  always_comb begin
    fg_nxt = fg_r;
    bg_nxt = bg_r;
    if (cfg_we) begin
      case (cfg_index)
        tcw_pkg::REG_FG: fg_nxt = cfg_wdata;
        tcw_pkg::REG_BG: bg_nxt = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r <= tcw_pkg::RESET_FG;
      bg_r <= tcw_pkg::RESET_BG;
    end else begin
      fg_r <= fg_nxt;
      bg_r <= bg_nxt;
    end
  end

  assign attr = (8'(bg_r) << tcw_pkg::BG_SHIFT) | 8'(fg_r);

  tcw_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_cmd    (q_cmd)
  );

  tcw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .attr      (attr),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_cmd     (q_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef NO_ASSERTIONS
  // A taken item always leaves the command queue non-empty in the next cycle.
  a_push_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> q_valid)
    else $error("accepted item missing from the command queue");

  // The reported cursor row stays inside the frame and the column never exceeds COLS.
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((int'(out_data.cursor_row_out) < tcw_pkg::ROWS) &&
                   (int'(out_data.cursor_col_out) <= tcw_pkg::COLS)))
    else $error("cursor outside the frame");

  // Reset always starts the clearing pass, so no command is taken straight after it.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !q_ready)
    else $error("command taken before the reset clearing pass");
`endif

endmodule
